### design/mbsw_pkg.sv
// Shared types and constants for the MSB-first bit stream writer.
package mbsw_pkg;

    typedef enum logic [1:0] {
        FUNC_BITS   = 2'd0,
        FUNC_LE24   = 2'd1,
        FUNC_VARINT = 2'd2,
        FUNC_ALIGN  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BITS  = 2'd1,
        ST_ALIGN = 2'd2,
        ST_BYTES = 2'd3
    } state_t;

    localparam logic [5:0] MAX_BITS       = 6'd32;
    localparam logic [3:0] BYTE_BITS      = 4'd8;
    localparam logic [7:0] VARINT_CONT    = 8'h80;
    localparam logic [1:0] LE24_LAST_IDX  = 2'd2;

    typedef struct packed {
        logic load;
        logic bits_step;
        logic align_step;
        logic byte_step;
        logic varint;
        logic align_only;
    } cmd_t;

    typedef struct packed {
        logic adv;
        logic bits_done;
        logic byte_last;
    } status_t;

endpackage

### design/mbsw_ctrl.sv
// Controller state machine for the MSB-first bit stream writer.
module mbsw_ctrl
    import mbsw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  func_t         in_func,
    input  status_t       status,
    output logic          in_ready,
    output cmd_t          cmd
);

    state_t state_reg, state_next;
    func_t  op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= FUNC_BITS;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_func;
                    state_next = (in_func == FUNC_BITS) ? ST_BITS : ST_ALIGN;
                end
            end
            ST_BITS:
            begin
                if (status.adv && status.bits_done)
                    state_next = ST_IDLE;
            end
            ST_ALIGN:
            begin
                if (status.adv)
                    state_next = (op_reg == FUNC_ALIGN) ? ST_IDLE : ST_BYTES;
            end
            ST_BYTES:
            begin
                if (status.adv && status.byte_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        cmd.varint     = (op_reg == FUNC_VARINT);
        cmd.align_only = (op_reg == FUNC_ALIGN);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_BITS:  cmd.bits_step  = status.adv;
            ST_ALIGN: cmd.align_step = status.adv;
            ST_BYTES: cmd.byte_step  = status.adv;
            default:  cmd            = '0;
        endcase
    end

endmodule

### design/mbsw_datapath.sv
// Datapath: partial byte, field shifter, byte sequencer and output register.
module mbsw_datapath
    import mbsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  func_t       in_func,
    input  logic [31:0] in_value,
    input  logic [5:0]  in_bit_count,
    input  logic        out_ready,
    output status_t     status,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    logic [7:0]  partial_reg, partial_next;
    logic [3:0]  free_reg, free_next;
    logic [31:0] val_reg, val_next;
    logic [5:0]  rem_reg, rem_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        emit;

    logic [5:0]  rem_clamp;
    logic [3:0]  take;
    logic [7:0]  chunk;
    logic [7:0]  merged;
    logic [3:0]  free_after;
    logic [5:0]  rem_after;
    logic        vcont;

    assign rem_clamp  = (in_bit_count > MAX_BITS) ? MAX_BITS : in_bit_count;
    assign take       = (rem_reg < {2'b00, free_reg}) ? rem_reg[3:0] : free_reg;
    assign chunk      = val_reg[31:24] >> (BYTE_BITS - take);
    assign merged     = partial_reg | (chunk << (free_reg - take));
    assign free_after = free_reg - take;
    assign rem_after  = rem_reg - {2'b00, take};
    assign vcont      = (val_reg[31:7] != 25'd0);

    assign status.adv       = !out_valid_reg || out_ready;
    assign status.bits_done = (rem_after == 6'd0);
    assign status.byte_last = cmd.varint ? !vcont : (idx_reg == LE24_LAST_IDX);

    always_comb
    begin
        partial_next  = partial_reg;
        free_next     = free_reg;
        val_next      = val_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        emit          = 1'b0;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        if (cmd.load)
        begin
            rem_next = rem_clamp;
            idx_next = 2'd0;
            val_next = (in_func == FUNC_BITS) ? (in_value << (MAX_BITS - rem_clamp))
                                              : in_value;
        end
        else if (cmd.bits_step)
        begin
            val_next = val_reg << take;
            rem_next = rem_after;
            if (free_after == 4'd0)
            begin
                emit          = 1'b1;
                out_byte_next = merged;
                out_last_next = (rem_after < 6'(BYTE_BITS));
                partial_next  = 8'd0;
                free_next     = BYTE_BITS;
            end
            else
            begin
                partial_next = merged;
                free_next    = free_after;
            end
        end
        else if (cmd.align_step)
        begin
            if (free_reg != BYTE_BITS)
            begin
                emit          = 1'b1;
                out_byte_next = partial_reg;
                out_last_next = cmd.align_only;
                partial_next  = 8'd0;
                free_next     = BYTE_BITS;
            end
        end
        else if (cmd.byte_step)
        begin
            emit          = 1'b1;
            out_last_next = status.byte_last;
            idx_next      = idx_reg + 2'd1;
            if (cmd.varint)
            begin
                out_byte_next = {vcont, val_reg[6:0]};
                val_next      = val_reg >> 7;
            end
            else
            begin
                out_byte_next = val_reg[7:0];
                val_next      = val_reg >> 8;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= 8'd0;
            free_reg      <= BYTE_BITS;
            rem_reg       <= 6'd0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
            free_reg    <= free_next;
            rem_reg     <= rem_next;
            idx_reg     <= idx_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

### design/msb_first_bit_stream_writer.sv
// MSB-first bit stream writer top level: stream ports, controller and datapath.
// Each input transaction is one operation (write bits, 24-bit little-endian, varint or
// align) and yields zero to six output byte transactions, tlast on the final one. After
// the accept cycle the block works one step per cycle, each step gated by the output
// register being free or drained: write bits takes one step per chunk that fits the
// partial byte (one step for a zero count, 4 or 5 steps for 32 bits), the other
// operations take one align step plus one step per byte (3 for 24-bit, 1 to 5 for
// varint). One output byte per cycle is the limit. A new input is taken once the last byte
// of the previous one sits in the output register.
module msb_first_bit_stream_writer
    import mbsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[1:0], value[33:2], bit_count[39:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast
);

    cmd_t    cmd;
    status_t status;
    func_t   in_func;

    assign in_func = func_t'(s_tdata[1:0]);

    mbsw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (in_func),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    mbsw_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_func      (in_func),
        .in_value     (s_tdata[33:2]),
        .in_bit_count (s_tdata[39:34]),
        .out_ready    (m_tready),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_byte     (m_tdata),
        .out_last     (m_tlast)
    );

`ifndef SYNTHESIS
    // after every accepted transaction the block is not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // a byte still waiting at input accept must close the previous item
    a_pending_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tvalid && !m_tready |-> m_tlast)
        else $error("new input accepted mid-item");
`endif

endmodule
